// File: sv/cln_pkg.sv
// Shared types, codes and the power-up nibble table for the LCD nibble sequencer.
package cln_pkg;

  typedef enum logic [1:0] {
    PH_POWERUP,
    PH_READY,
    PH_ESCAPE
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CMD,
    OP_DATA
  } op_t;

  typedef struct packed {
    logic       powerup;
    op_t        op;
    logic [7:0] value;
  } job_t;

  localparam logic       REG_ESCAPE   = 1'b0;
  localparam logic       REG_CLEAR    = 1'b1;

  localparam logic [7:0] ESCAPE_RESET = 8'h1B;
  localparam logic [7:0] CLEAR_RESET  = 8'hFF;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] ASCII_AT     = 8'h40;

  localparam logic [3:0] STEP_FIRST   = 4'd0;
  localparam logic [3:0] STEP_INIT_END = 4'd13;
  localparam logic [3:0] STEP_HI      = 4'd14;
  localparam logic [3:0] STEP_LO      = 4'd15;

  // Power-up sequence as seen on the bus: 0x30 x3 and 0x20 as lone high
  // nibbles, then 0x28, 0x0C, 0x06, 0x01, 0x02 as nibble pairs.
  function automatic logic [3:0] init_nibble(input logic [3:0] step);
    logic [3:0] nib;
    case (step)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd7:             nib = 4'hC;
      4'd9:             nib = 4'h6;
      4'd11:            nib = 4'h1;
      4'd13:            nib = 4'h2;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

// File: sv/cln_front.sv
// Front end: config registers, escape tracking and byte classification.
module cln_front
  import cln_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       cfg_valid,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output logic       push_valid,
  input  logic       push_ready,
  output job_t       push_job
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] escape_code_r;
  logic [7:0] clear_code_r;
  logic       accept;

  assign in_ready = push_ready;
  assign accept   = in_valid & push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_code_r <= ESCAPE_RESET;
      clear_code_r  <= CLEAR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ESCAPE) begin
        escape_code_r <= cfg_data;
      end else begin
        clear_code_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_POWERUP;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    push_job.powerup = (phase_r == PH_POWERUP);
    push_job.op      = OP_NONE;
    push_job.value   = in_byte_value;
    case (phase_r)
      PH_ESCAPE: begin
        if (in_byte_value[7]) begin
          push_job.op = OP_CMD;
        end else if (in_byte_value == ASCII_AT) begin
          push_job.op    = OP_CMD;
          push_job.value = CMD_HOME;
        end
        if (accept) begin
          phase_nxt = PH_READY;
        end
      end
      default: begin
        // clear wins over escape when both codes match
        if (in_byte_value == clear_code_r) begin
          push_job.op    = OP_CMD;
          push_job.value = CMD_CLEAR;
          if (accept) begin
            phase_nxt = PH_READY;
          end
        end else if (in_byte_value == escape_code_r) begin
          if (accept) begin
            phase_nxt = PH_ESCAPE;
          end
        end else begin
          push_job.op = OP_DATA;
          if (accept) begin
            phase_nxt = PH_READY;
          end
        end
      end
    endcase
    // drop items that cause no bus write
    push_valid = accept & (push_job.powerup | (push_job.op != OP_NONE));
  end

endmodule

// File: sv/cln_queue.sv
// Small job queue between the classifier and the nibble sequencer.
module cln_queue
  import cln_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/cln_back.sv
// Back end: steps through one job and drives the registered nibble output.
module cln_back
  import cln_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_nibble,
  output logic       out_reg_select,
  output logic       out_last
);

  job_t       job_r;
  logic       job_valid_r;
  logic [3:0] step_r;
  logic       out_valid_r;
  logic [3:0] nibble_r;
  logic       rs_r;
  logic       last_r;

  logic       load, done;
  logic [3:0] last_step;
  logic [3:0] nib;
  logic       rs;

  always_comb begin
    last_step = (job_r.op == OP_NONE) ? STEP_INIT_END : STEP_LO;
    load      = job_valid_r & (~out_valid_r | out_ready);
    done      = load & (step_r == last_step);
    pop       = head_valid & (~job_valid_r | done);
    case (step_r)
      STEP_HI: begin
        nib = job_r.value[7:4];
        rs  = (job_r.op == OP_DATA);
      end
      STEP_LO: begin
        nib = job_r.value[3:0];
        rs  = (job_r.op == OP_DATA);
      end
      default: begin
        nib = init_nibble(step_r);
        rs  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= STEP_FIRST;
    end else if (pop) begin
      job_valid_r <= 1'b1;
      step_r      <= head_job.powerup ? STEP_FIRST : STEP_HI;
    end else if (done) begin
      job_valid_r <= 1'b0;
    end else if (load) begin
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nibble_r <= nib;
      rs_r     <= rs;
      last_r   <= (step_r == last_step);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_nibble     = nibble_r;
  assign out_reg_select = rs_r;
  assign out_last       = last_r;

endmodule

// File: sv/char_lcd_nibble_sequencer.sv
// Top level of the character LCD 4-bit nibble sequencer.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte_value) takes one display byte
//   per item. Output channel (out_valid/out_ready) emits nibble writes with
//   out_reg_select (0 command, 1 data) and out_last on the final nibble of
//   the item. Config channel writes escape_code (index 0) and clear_code
//   (index 1); cfg_ready is always high.
//   An accepted item passes the job queue and the job register before its
//   first nibble reaches the output register, which gives one nibble per
//   cycle while out_ready is high and work is queued; a data or command byte
//   gives two nibbles, and the first byte after reset is preceded by the
//   14 power-up nibbles. Escape and dropped escaped bytes add no nibbles.
//   Reset returns both codes to their defaults and re-arms the power-up
//   sequence. When the receiver stalls, the output register holds, the
//   sequencer stops and the job queue fills; in_ready drops only when
//   the queue is full.
module char_lcd_nibble_sequencer
  import cln_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_nibble,
  output logic       out_reg_select,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic push_valid, push_ready;
  job_t push_job;
  logic head_valid, pop;
  job_t head_job;

  // config writes are always accepted and go straight into the code registers
  assign cfg_ready = 1'b1;

  // classify bytes and track escape/power-up state
  cln_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_value (in_byte_value),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_job      (push_job)
  );

  // decouple the classifier from the bus sequencer
  cln_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_job    (head_job)
  );

  // play table and byte nibbles onto the output register
  cln_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_nibble     (out_nibble),
    .out_reg_select (out_reg_select),
    .out_last       (out_last)
  );

endmodule

// File: sim/char_lcd_nibble_sequencer_tb.sv
// Self-checking testbench for the character LCD nibble sequencer.
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_tb
  import cln_pkg::*;
();

  // One nibble write as it appears on the result channel.
  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic       last;
  } lcd_write_t;

  // Scoreboard: mirrors the sequencer state, expands each accepted byte into
  // the nibble writes it should cause and checks them in order.
  class lcd_scoreboard;
    phase_t       phase;
    logic         four_bit;
    logic [7:0]   escape_code;
    logic [7:0]   clear_code;
    logic [7:0]   power_up_seq [9];
    lcd_write_t   pending_writes [$];
    lcd_write_t   item_writes [$];
    int           errors;
    int           writes_seen;

    function new();
      power_up_seq = '{8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h0C, 8'h06, 8'h01, 8'h02};
      phase        = PH_POWERUP;
      four_bit     = 1'b0;
      escape_code  = ESCAPE_RESET;
      clear_code   = CLEAR_RESET;
      errors       = 0;
      writes_seen  = 0;
    endfunction

    function void set_code(logic idx, logic [7:0] value);
      if (idx == REG_ESCAPE) escape_code = value;
      else clear_code = value;
    endfunction

    function void add_write(logic [3:0] nib, logic rs);
      lcd_write_t w;
      w.nibble     = nib;
      w.reg_select = rs;
      w.last       = 1'b0;
      item_writes.push_back(w);
    endfunction

    // In eight-bit mode only the high nibble goes out; a 0x2X command then
    // switches the bus to four-bit mode.
    function void add_command(logic [7:0] c);
      add_write(c[7:4], 1'b0);
      if (four_bit) add_write(c[3:0], 1'b0);
      else if (c[5:4] == 2'b10) four_bit = 1'b1;
    endfunction

    function void note_byte(logic [7:0] b);
      item_writes.delete();
      if (phase == PH_POWERUP) begin
        foreach (power_up_seq[i]) add_command(power_up_seq[i]);
        phase = PH_READY;
      end
      if (phase == PH_ESCAPE) begin
        if (b[7]) add_command(b);
        else if (b == ASCII_AT) add_command(CMD_HOME);
        phase = PH_READY;
      end else begin
        phase = PH_READY;
        if (b == clear_code) add_command(CMD_CLEAR);
        else if (b == escape_code) phase = PH_ESCAPE;
        else begin
          add_write(b[7:4], 1'b1);
          add_write(b[3:0], 1'b1);
        end
      end
      if (item_writes.size() > 0) item_writes[item_writes.size() - 1].last = 1'b1;
      foreach (item_writes[i]) pending_writes.push_back(item_writes[i]);
    endfunction

    function void check_write(lcd_write_t got);
      lcd_write_t want;
      writes_seen++;
      if (pending_writes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected write nibble=%h rs=%b last=%b",
                   got.nibble, got.reg_select, got.last);
        return;
      end
      want = pending_writes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: write %0d expected nibble=%h rs=%b last=%b, got nibble=%h rs=%b last=%b",
                   writes_seen, want.nibble, want.reg_select, want.last,
                   got.nibble, got.reg_select, got.last);
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_nibble;
  logic       out_reg_select;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  lcd_scoreboard sb = new();

  int idle_pct  = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int bytes_sent = 0;
  int code_writes = 0;

  char_lcd_nibble_sequencer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_nibble     (out_nibble),
    .out_reg_select (out_reg_select),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: drop ready at random according to the current pressure phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: values read right after the edge are the ones the edge sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_write({out_nibble, out_reg_select, out_last});
  end

  // Offer one byte, idling first at random; hold valid and payload until taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Drop valid, wait for every expected write, then allow for bytes that
  // cause no write and may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_code(input logic idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_code(idx, value);
    code_writes++;
  endtask

  // Random traffic: mostly random data bytes, with escape sequences
  // and clears mixed in so every branch of the command decoder is reached.
  task automatic random_bytes(input int count);
    int n;
    int pick;
    logic [7:0] b;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_byte(sb.escape_code);
        pick = $urandom_range(99);
        if (pick < 40) b = 8'h80 | 8'($urandom_range(127));
        else if (pick < 60) b = ASCII_AT;
        else if (pick < 75) b = sb.escape_code;
        else b = 8'($urandom_range(255));
        send_byte(b);
        n += 2;
      end else if (pick < 35) begin
        send_byte(sb.clear_code);
        n++;
      end else begin
        send_byte(8'($urandom_range(255)));
        n++;
      end
    end
  endtask

  initial begin
    logic [7:0] codes [2];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first byte plays the power-up table and then shows up as data.
    write_code(REG_ESCAPE, ESCAPE_RESET);
    write_code(REG_CLEAR, CLEAR_RESET);
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'hFF);            // clear
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(ESCAPE_RESET);     // cursor address
    send_byte(8'hA5);
    send_byte(ESCAPE_RESET);     // home
    send_byte(ASCII_AT);
    send_byte(ESCAPE_RESET);     // dropped escaped byte
    send_byte(8'h78);
    send_byte(ESCAPE_RESET);     // escape code while armed, bit 7 clear: dropped
    send_byte(ESCAPE_RESET);
    send_byte(ESCAPE_RESET);     // clear code while armed goes out as cursor command
    send_byte(8'hFF);
    settle();

    // Equal codes: the clear wins, old codes become plain data.
    write_code(REG_ESCAPE, 8'h55);
    write_code(REG_CLEAR, 8'h55);
    send_byte(8'h55);
    send_byte(8'h1B);
    send_byte(8'hFF);
    settle();

    // Extreme codes; escape code with bit 7 set while armed becomes a cursor command.
    write_code(REG_ESCAPE, 8'hFF);
    write_code(REG_CLEAR, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    settle();

    // Random part: one pressure phase per code setting.
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin idle_pct = 0;  stall_pct = 0;  codes = '{ESCAPE_RESET, CLEAR_RESET}; end
        1: begin idle_pct = 78; stall_pct = 0;
                 codes = '{8'($urandom_range(255)), 8'($urandom_range(255))}; end
        2: begin idle_pct = 0;  stall_pct = 78; codes = '{8'h00, 8'hFF}; end
        default: begin idle_pct = 16; stall_pct = 16;
                 codes = '{8'($urandom_range(255)), 8'($urandom_range(255))}; end
      endcase
      write_code(REG_ESCAPE, codes[0]);
      write_code(REG_CLEAR, codes[1]);
      random_bytes(22);
      settle();
    end

    // Let any stray write surface before judging.
    stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("Covered %0d bytes and %0d nibble writes over %0d code writes,",
             bytes_sent, sb.writes_seen, code_writes);
    $display("with idle and stall pressure on both channels; %0d mismatches.", sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing write ends here.
  initial begin
    #200000;
    $display("ERROR: timeout with %0d writes still expected", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
